// ===== src/pft_pkg.sv =====
// Shared constants, types and a function for the planar pose transform.
package pft_pkg;

   localparam int POS_W        = 32;
   localparam int ANG_W        = 32;
   localparam int HEAD_W       = 31;
   localparam int DIFF_W       = 33;
   localparam int CORD_W       = 34;
   localparam int PROD_W       = DIFF_W + CORD_W;
   localparam int RND_W        = PROD_W - 30;
   localparam int SUM_W        = RND_W + 2;
   localparam int STAGES_DEF   = 24;
   localparam int STAGES_MAX   = 32;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [1:0] CSR_ORIGIN_X       = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y       = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_HEADING = 2'd2;

   localparam logic signed [CORD_W-1:0] PI_Q      = 34'sd843314857;
   localparam logic signed [CORD_W-1:0] TWO_PI_Q  = 34'sd1686629714;
   localparam logic signed [CORD_W-1:0] HALF_PI_Q = 34'sd421657428;
   localparam logic signed [CORD_W-1:0] GAIN_Q    = 34'sd652032874;

   localparam logic [31:0] ATAN_Q30 [STAGES_MAX] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
      32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
      32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
   };

   typedef struct packed {
      logic                       func;
      logic                       neg;
      logic signed [DIFF_W-1:0]   a;
      logic signed [DIFF_W-1:0]   b;
      logic signed [CORD_W-1:0]   z;
      logic signed [HEAD_W-1:0]   heading;
   } pft_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] heading;
   } pft_origin_type;

   // Truncated remainder by two pi, then folded into [-pi, pi].
   function automatic logic signed [CORD_W-1:0] wrap_angle(
      input logic signed [CORD_W-1:0] t);
      logic signed [CORD_W-1:0] r;
      r = t;
      if (t >= 0) begin
         if (r >= TWO_PI_Q) r = r - TWO_PI_Q;
         if (r >= TWO_PI_Q) r = r - TWO_PI_Q;
         if (r > PI_Q) r = r - TWO_PI_Q;
      end else begin
         if (r <= -TWO_PI_Q) r = r + TWO_PI_Q;
         if (r <= -TWO_PI_Q) r = r + TWO_PI_Q;
         if (r < -PI_Q) r = r + TWO_PI_Q;
      end
      return r;
   endfunction

endpackage

// ===== src/pft_front.sv =====
// Front end: input register, heading wrap, quadrant fold and origin offset.
module pft_front
   import pft_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   input  logic signed [POS_W-1:0] req_point_x,
   input  logic signed [POS_W-1:0] req_point_y,
   input  logic signed [ANG_W-1:0] req_point_heading,
   input  pft_origin_type          origin,
   output logic                    push_valid,
   input  logic                    push_ready,
   output pft_item_type            push_item
);

   logic                    valid_ff;
   logic                    func_ff;
   logic signed [POS_W-1:0] px_ff, py_ff, ph_ff;
   logic                    load;
   logic signed [CORD_W-1:0] t, a_w, a_f;
   logic                    neg;

   assign req_stall  = valid_ff & ~push_ready;
   assign load       = ~valid_ff | push_ready;
   assign push_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= req_valid;
      end
      if (load && req_valid) begin
         func_ff <= req_func;
         px_ff   <= req_point_x;
         py_ff   <= req_point_y;
         ph_ff   <= req_point_heading;
      end
   end

   always_comb begin
      if (func_ff) begin
         t = CORD_W'(ph_ff) - CORD_W'(origin.heading);
      end else begin
         t = CORD_W'(ph_ff) + CORD_W'(origin.heading);
      end
      a_w = wrap_angle(CORD_W'(origin.heading));
      neg = 1'b0;
      a_f = a_w;
      if (a_w > HALF_PI_Q) begin
         a_f = a_w - PI_Q;
         neg = 1'b1;
      end else if (a_w < -HALF_PI_Q) begin
         a_f = a_w + PI_Q;
         neg = 1'b1;
      end
      push_item.func    = func_ff;
      push_item.neg     = neg;
      push_item.z       = a_f <<< 2;
      push_item.heading = HEAD_W'(wrap_angle(t));
      if (func_ff) begin
         push_item.a = DIFF_W'(px_ff) - DIFF_W'(origin.x);
         push_item.b = DIFF_W'(py_ff) - DIFF_W'(origin.y);
      end else begin
         push_item.a = DIFF_W'(px_ff);
         push_item.b = DIFF_W'(py_ff);
      end
   end

endmodule

// ===== src/pft_queue.sv =====
// Short register queue between front and back ends.
module pft_queue
   import pft_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  pft_item_type push_item,
   output logic         pop_valid,
   input  logic         pop,
   output pft_item_type pop_item
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   pft_item_type  mem_ff [QUEUE_DEPTH];
   logic [IW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign push_ready = count_ff < CW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & pop_valid;
   assign pop_item   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == IW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + CW'(do_push) - CW'(do_pop);
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== src/pft_back.sv =====
// Back end: pipelined CORDIC, products, rounding, sum and saturation.
module pft_back
   import pft_pkg::*;
#(
   parameter int CORDIC_STAGES = STAGES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   output logic                     item_pop,
   input  pft_item_type             item,
   input  pft_origin_type           origin,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [POS_W-1:0]  rsp_out_x,
   output logic signed [POS_W-1:0]  rsp_out_y,
   output logic signed [HEAD_W-1:0] rsp_out_heading,
   output logic                     rsp_saturated
);

   typedef struct packed {
      logic                      func;
      logic                      neg;
      logic signed [DIFF_W-1:0]  a;
      logic signed [DIFF_W-1:0]  b;
      logic signed [CORD_W-1:0]  x;
      logic signed [CORD_W-1:0]  y;
      logic signed [CORD_W-1:0]  z;
      logic signed [HEAD_W-1:0]  heading;
   } stage_type;

   stage_type stage_ff [CORDIC_STAGES+1];
   stage_type stage_in [CORDIC_STAGES+1];
   logic      v_ff     [CORDIC_STAGES+1];

   logic                     mv_ff, ov_ff, adv;
   logic                     mfunc_ff;
   logic signed [HEAD_W-1:0] mhead_ff;
   logic signed [PROD_W-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [CORD_W-1:0] c, s;
   logic signed [RND_W-1:0]  r_ac, r_bs, r_as, r_bc;
   logic signed [SUM_W-1:0]  sx, sy;
   logic signed [POS_W-1:0]  ox_in, oy_in;
   logic                     sat_in;
   logic signed [POS_W-1:0]  ox_ff, oy_ff;
   logic signed [HEAD_W-1:0] oh_ff;
   logic                     sat_ff;

   localparam logic signed [SUM_W-1:0] MAXV = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] MINV = -SUM_W'(64'sd2147483648);
   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(64'sd536870912);

   assign adv      = ~ov_ff | ~rsp_stall;
   assign item_pop = adv;

   always_comb begin
      stage_in[0].func    = item.func;
      stage_in[0].neg     = item.neg;
      stage_in[0].a       = item.a;
      stage_in[0].b       = item.b;
      stage_in[0].x       = GAIN_Q;
      stage_in[0].y       = '0;
      stage_in[0].z       = item.z;
      stage_in[0].heading = item.heading;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      localparam logic signed [CORD_W-1:0] ATAN = CORD_W'(ATAN_Q30[i]);
      always_comb begin
         stage_in[i+1] = stage_ff[i];
         if (stage_ff[i].z >= 0) begin
            stage_in[i+1].x = stage_ff[i].x - (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y + (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z - ATAN;
         end else begin
            stage_in[i+1].x = stage_ff[i].x + (stage_ff[i].y >>> i);
            stage_in[i+1].y = stage_ff[i].y - (stage_ff[i].x >>> i);
            stage_in[i+1].z = stage_ff[i].z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CORDIC_STAGES; k++) v_ff[k] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= item_valid;
         for (int k = 1; k <= CORDIC_STAGES; k++) v_ff[k] <= v_ff[k-1];
      end
      if (adv) begin
         for (int k = 0; k <= CORDIC_STAGES; k++) stage_ff[k] <= stage_in[k];
      end
   end

   always_comb begin
      c = stage_ff[CORDIC_STAGES].neg ? -stage_ff[CORDIC_STAGES].x
                                      : stage_ff[CORDIC_STAGES].x;
      s = stage_ff[CORDIC_STAGES].neg ? -stage_ff[CORDIC_STAGES].y
                                      : stage_ff[CORDIC_STAGES].y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else if (adv) begin
         mv_ff <= v_ff[CORDIC_STAGES];
      end
      if (adv) begin
         mfunc_ff <= stage_ff[CORDIC_STAGES].func;
         mhead_ff <= stage_ff[CORDIC_STAGES].heading;
         ac_ff    <= PROD_W'(stage_ff[CORDIC_STAGES].a) * PROD_W'(c);
         bs_ff    <= PROD_W'(stage_ff[CORDIC_STAGES].b) * PROD_W'(s);
         as_ff    <= PROD_W'(stage_ff[CORDIC_STAGES].a) * PROD_W'(s);
         bc_ff    <= PROD_W'(stage_ff[CORDIC_STAGES].b) * PROD_W'(c);
      end
   end

   always_comb begin
      r_ac = RND_W'((ac_ff + HALF_LSB) >>> 30);
      r_bs = RND_W'((bs_ff + HALF_LSB) >>> 30);
      r_as = RND_W'((as_ff + HALF_LSB) >>> 30);
      r_bc = RND_W'((bc_ff + HALF_LSB) >>> 30);
      if (mfunc_ff) begin
         sx = SUM_W'(r_ac) + SUM_W'(r_bs);
         sy = SUM_W'(r_bc) - SUM_W'(r_as);
      end else begin
         sx = SUM_W'(r_ac) - SUM_W'(r_bs) + SUM_W'(origin.x);
         sy = SUM_W'(r_as) + SUM_W'(r_bc) + SUM_W'(origin.y);
      end
      sat_in = 1'b0;
      ox_in  = POS_W'(sx);
      oy_in  = POS_W'(sy);
      if (sx > MAXV) begin
         ox_in  = POS_W'(MAXV);
         sat_in = 1'b1;
      end else if (sx < MINV) begin
         ox_in  = POS_W'(MINV);
         sat_in = 1'b1;
      end
      if (sy > MAXV) begin
         oy_in  = POS_W'(MAXV);
         sat_in = 1'b1;
      end else if (sy < MINV) begin
         oy_in  = POS_W'(MINV);
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= mv_ff;
      end
      if (adv) begin
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         oh_ff  <= mhead_ff;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_out_x       = ox_ff;
   assign rsp_out_y       = oy_ff;
   assign rsp_out_heading = oh_ff;
   assign rsp_saturated   = sat_ff;

endmodule

// ===== src/pose_frame_transform.sv =====
// Planar rigid pose transform between a local frame and the global frame.
// Registers from req to rsp: front input, queue, CORDIC stages, products, output.
// Throughput: one transfer per cycle; back end holds while rsp_valid && rsp_stall.
// A two-entry queue lets the front take items while the back holds, until full.
// Reset (synchronous) empties all stages and clears the origin registers to zero.
module pose_frame_transform
   import pft_pkg::*;
#(
   parameter int CORDIC_STAGES = STAGES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic signed [POS_W-1:0]  req_point_x,
   input  logic signed [POS_W-1:0]  req_point_y,
   input  logic signed [ANG_W-1:0]  req_point_heading,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [POS_W-1:0]  rsp_out_x,
   output logic signed [POS_W-1:0]  rsp_out_y,
   output logic signed [HEAD_W-1:0] rsp_out_heading,
   output logic                     rsp_saturated,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [POS_W-1:0]         csr_wdata
);

   pft_origin_type origin_ff;
   logic           push_valid, push_ready, pop_valid, pop;
   pft_item_type   push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X:       origin_ff.x       <= csr_wdata;
            CSR_ORIGIN_Y:       origin_ff.y       <= csr_wdata;
            CSR_ORIGIN_HEADING: origin_ff.heading <= csr_wdata;
            default: ;
         endcase
      end
   end

   pft_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_point_heading (req_point_heading),
      .origin            (origin_ff),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_item         (push_item)
   );

   pft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   pft_back #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (pop_valid),
      .item_pop        (pop),
      .item            (pop_item),
      .origin          (origin_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_heading (rsp_out_heading),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

// ===== verif/testbench.sv =====
// Testbench for pose_frame_transform: directed and random points checked against a predictor.
`timescale 1ns / 1ps
module testbench;
   import pft_pkg::*;

   localparam int STAGES = STAGES_DEF;
   localparam longint PI_L = 843314857;
   localparam longint TWO_PI_L = 2 * PI_L;
   localparam longint HALF_PI_L = 421657428;
   localparam longint GAIN_L = 652032874;
   localparam int LIMIT = 400000;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [30:0] heading;
      logic               sat;
   } pose_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_func = 0;
   logic signed [31:0] req_point_x = 0, req_point_y = 0, req_point_heading = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_out_x, rsp_out_y;
   logic signed [30:0] rsp_out_heading;
   logic rsp_saturated;
   logic csr_we = 0;
   logic [1:0] csr_index = CSR_ORIGIN_X;
   logic [31:0] csr_wdata = 0;

   int errors = 0;
   int cycles = 0;
   bit stall_on = 1;

   longint origin_x = 0, origin_y = 0, origin_h = 0;

   pose_frame_transform #(.CORDIC_STAGES(STAGES)) uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic longint fold_angle(longint t);
      longint r;
      r = t % TWO_PI_L;
      if (r > PI_L) r -= TWO_PI_L;
      else if (r < -PI_L) r += TWO_PI_L;
      return r;
   endfunction

   function automatic longint round_q30(longint p, longint k);
      return (p * k + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint clip(longint v, ref logic flag);
      if (v > 64'sd2147483647) begin flag = 1; return 64'sd2147483647; end
      if (v < -64'sd2147483648) begin flag = 1; return -64'sd2147483648; end
      return v;
   endfunction

   function automatic pose_result_type transform_pose(logic f, longint px, longint py,
                                                      longint ph);
      longint atan_tab [32];
      longint a, x, y, z, nx, s, c, rx, ry;
      bit neg;
      logic sat;
      pose_result_type r;
      for (int i = 0; i < 32; i++) atan_tab[i] = longint'(ATAN_Q30[i]);
      a = fold_angle(origin_h);
      neg = 0;
      if (a > HALF_PI_L) begin a -= PI_L; neg = 1; end
      else if (a < -HALF_PI_L) begin a += PI_L; neg = 1; end
      x = GAIN_L; y = 0; z = a * 4;
      for (int i = 0; i < STAGES && i < 32; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
         end
         x = nx;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
      sat = 0;
      if (f == 0) begin
         rx = round_q30(px, c) - round_q30(py, s) + origin_x;
         ry = round_q30(px, s) + round_q30(py, c) + origin_y;
         r.heading = 31'(fold_angle(ph + origin_h));
      end else begin
         rx = round_q30(px - origin_x, c) + round_q30(py - origin_y, s);
         ry = round_q30(py - origin_y, c) - round_q30(px - origin_x, s);
         r.heading = 31'(fold_angle(ph - origin_h));
      end
      r.x = 32'(clip(rx, sat));
      r.y = 32'(clip(ry, sat));
      r.sat = sat;
      return r;
   endfunction

   class pose_scoreboard;
      pose_result_type pending[$];

      function void note_point(logic f, logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] ph);
         pending.push_back(transform_pose(f, px, py, ph));
      endfunction

      task check_result(logic signed [31:0] x, logic signed [31:0] y,
                        logic signed [30:0] h, logic s);
         pose_result_type e;
         if (pending.size() == 0) begin
            report("unexpected transfer", x, 0);
            return;
         end
         e = pending.pop_front();
         if (x !== e.x) report("out_x", x, e.x);
         if (y !== e.y) report("out_y", y, e.y);
         if (h !== e.heading) report("out_heading", h, e.heading);
         if (s !== e.sat) report("saturated", s, e.sat);
      endtask
   endclass

   pose_scoreboard board = new();

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_point(req_func, req_point_x, req_point_y, req_point_heading);
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_out_x, rsp_out_y, rsp_out_heading, rsp_saturated);
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // receiver back-pressure
   initial begin
      int n;
      forever begin
         @(posedge clock);
         n = stall_on ? gap_len() : 0;
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
      end
   end

   task automatic send_point(logic f, logic [31:0] px, logic [31:0] py, logic [31:0] ph,
                             bit gaps);
      int n;
      n = gaps ? gap_len() : 0;
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_point_x <= px;
      req_point_y <= py;
      req_point_heading <= ph;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (STAGES + 10) @(posedge clock);
   endtask

   task automatic write_origin(logic [1:0] idx, logic [31:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_ORIGIN_X: origin_x = $signed(v);
         CSR_ORIGIN_Y: origin_y = $signed(v);
         CSR_ORIGIN_HEADING: origin_h = $signed(v);
         default: ;
      endcase
   endtask

   function automatic logic [31:0] pick_value(bit angle);
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom();
         3: return angle ? $urandom_range(0, 2 * 843314857) - 843314857
                         : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         default: return angle ? $urandom_range(0, 4 * 843314857) - 2 * 843314857
                               : $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
      endcase
   endfunction

   initial begin
      logic [31:0] headings [6];
      headings = '{32'h0, 32'd843314857, -32'd843314857, 32'd421657429,
                   32'h7fff_ffff, 32'h8000_0000};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset origin, extremes and both directions
      send_point(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
      send_point(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_point(0, 32'h0001_0000, 32'h0, 32'd843314857, 0);
      send_point(1, 32'h0, 32'hffff_0000, -32'd843314857, 0);
      drain();
      write_origin(CSR_ORIGIN_X, 32'h7fff_ffff);
      write_origin(CSR_ORIGIN_Y, 32'h8000_0000);
      write_origin(CSR_ORIGIN_HEADING, 32'd843314857);
      send_point(0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
      send_point(1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
      send_point(0, 32'h0, 32'h0, 32'h0, 0);
      send_point(1, 32'h0010_0000, 32'hfff0_0000, 32'd421657428, 0);
      drain();
      write_origin(3, 32'hdead_beef);
      write_origin(CSR_ORIGIN_HEADING, 32'h8000_0000);
      send_point(0, 32'h0123_4567, 32'hfedc_ba98, 32'h8000_0000, 0);
      send_point(1, 32'h0123_4567, 32'hfedc_ba98, 32'h7fff_ffff, 0);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         write_origin(CSR_ORIGIN_X, phase < 2 ? (phase ? 32'h8000_0000 : 32'h7fff_ffff)
                                              : pick_value(0));
         write_origin(CSR_ORIGIN_Y, pick_value(0));
         write_origin(CSR_ORIGIN_HEADING, phase < 6 ? headings[phase] : pick_value(1));
         stall_on = (phase != 3);
         for (int i = 0; i < 50; i++)
            send_point($urandom_range(0, 1), pick_value(0), pick_value(0), pick_value(1),
                       phase != 4);
         drain();
      end

      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// ===== sim.f =====
src/pft_pkg.sv
src/pft_front.sv
src/pft_queue.sv
src/pft_back.sv
src/pose_frame_transform.sv
verif/testbench.sv
